/* design/zlxc_pkg.sv */
package zlxc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;
    localparam int INDEX_BITS  = 16;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    // (a + b) * (c + d) with one growth bit on each side
    localparam int LPROD_BITS  = 2 * SAMPLE_BITS + 2;
    localparam int NUM_SUMS    = 5;
    localparam int MEM_BITS    = NUM_SUMS * ACC_BITS;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    localparam logic [2:0] REG_INVERT_VP         = 3'd0;
    localparam logic [2:0] REG_INVERT_VS         = 3'd1;
    localparam logic [2:0] REG_INVERT_DENSITY    = 3'd2;
    localparam logic [2:0] REG_INVERT_POROSITY   = 3'd3;
    localparam logic [2:0] REG_INVERT_SATURATION = 3'd4;

    typedef struct packed {
        logic [1:0]                    operation;
        logic [INDEX_BITS-1:0]         point_index;
        logic signed [SAMPLE_BITS-1:0] fwd_sxx;
        logic signed [SAMPLE_BITS-1:0] fwd_syy;
        logic signed [SAMPLE_BITS-1:0] fwd_sxy;
        logic signed [SAMPLE_BITS-1:0] fwd_vx;
        logic signed [SAMPLE_BITS-1:0] fwd_vy;
        logic signed [SAMPLE_BITS-1:0] adj_sxx;
        logic signed [SAMPLE_BITS-1:0] adj_syy;
        logic signed [SAMPLE_BITS-1:0] adj_sxy;
        logic signed [SAMPLE_BITS-1:0] adj_vx;
        logic signed [SAMPLE_BITS-1:0] adj_vy;
    } t_in;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] sum_lambda;
        logic signed [ACC_BITS-1:0] sum_mu_a;
        logic signed [ACC_BITS-1:0] sum_mu_b;
        logic signed [ACC_BITS-1:0] sum_mu_c;
        logic signed [ACC_BITS-1:0] sum_rho;
    } t_out;

    typedef struct packed {
        logic signed [LPROD_BITS-1:0] lambda;
        logic signed [PROD_BITS-1:0]  mu_a1;
        logic signed [PROD_BITS-1:0]  mu_a2;
        logic signed [PROD_BITS-1:0]  mu_b1;
        logic signed [PROD_BITS-1:0]  mu_b2;
        logic signed [PROD_BITS-1:0]  mu_c;
        logic signed [PROD_BITS-1:0]  rho1;
        logic signed [PROD_BITS-1:0]  rho2;
    } t_prod;

    typedef struct packed {
        logic invert_vp;
        logic invert_vs;
        logic invert_density;
        logic invert_porosity;
        logic invert_saturation;
    } t_cfg;

    typedef struct packed {
        logic lambda;
        logic mu;
        logic rho;
    } t_en;

endpackage

/* design/zlxc_ram.sv */
module zlxc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/zlxc_prod.sv */
module zlxc_prod (
    input  logic          i_clk,
    input  zlxc_pkg::t_in i_item,
    output zlxc_pkg::t_prod o_prod
);

    localparam int SB = zlxc_pkg::SAMPLE_BITS;

    logic signed [SB:0] w_fsum;
    logic signed [SB:0] w_asum;
    zlxc_pkg::t_prod    n_prod;
    zlxc_pkg::t_prod    r_prod;

    assign w_fsum = {i_item.fwd_sxx[SB-1], i_item.fwd_sxx}
                  + {i_item.fwd_syy[SB-1], i_item.fwd_syy};
    assign w_asum = {i_item.adj_sxx[SB-1], i_item.adj_sxx}
                  + {i_item.adj_syy[SB-1], i_item.adj_syy};

    always_comb begin
        n_prod.lambda = w_fsum * w_asum;
        n_prod.mu_a1  = i_item.fwd_sxx * i_item.adj_sxx;
        n_prod.mu_a2  = i_item.fwd_syy * i_item.adj_syy;
        n_prod.mu_b1  = i_item.fwd_syy * i_item.adj_sxx;
        n_prod.mu_b2  = i_item.fwd_sxx * i_item.adj_syy;
        n_prod.mu_c   = i_item.fwd_sxy * i_item.adj_sxy;
        n_prod.rho1   = i_item.fwd_vx * i_item.adj_vx;
        n_prod.rho2   = i_item.fwd_vy * i_item.adj_vy;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

/* design/zlxc_sat_add.sv */
module zlxc_sat_add (
    input  logic signed [zlxc_pkg::ACC_BITS-1:0]   i_acc,
    input  logic signed [zlxc_pkg::LPROD_BITS-1:0] i_prod,
    input  logic                                   i_en,
    output logic signed [zlxc_pkg::ACC_BITS-1:0]   o_sum
);

    localparam int AB = zlxc_pkg::ACC_BITS;
    localparam int PB = zlxc_pkg::LPROD_BITS;
    localparam int W  = AB + 1;

    localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
    localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};

    logic signed [W-1:0] w_wide;
    logic                w_ovf;

    assign w_wide = {i_acc[AB-1], i_acc} + {{(W-PB){i_prod[PB-1]}}, i_prod};
    // one guard bit: disagreement with the next bit means we left the range
    assign w_ovf  = w_wide[W-1] ^ w_wide[W-2];

    always_comb begin
        if (!i_en) begin
            o_sum = i_acc;
        end else if (w_ovf) begin
            o_sum = w_wide[W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            o_sum = w_wide[AB-1:0];
        end
    end

endmodule

/* design/zero_lag_xcorr_accumulator.sv */
// Zero-lag cross-correlation accumulator, five saturating 48-bit sums per grid point.
// Command channel: an item (i_item) is taken at a clock edge with start high and
// busy low. operation selects accumulate, clear of the enabled sums, or read.
// Each item gives one result on o_result, valid for exactly one cycle with o_done.
// The receiver cannot stall; the result must be taken in that cycle.
// Timing: the result is registered and shown while the sequencer is in its write-back
// state, and busy drops in the cycle after, so a new item is taken only after the last.
// Each item makes one read-modify-write of the shared sum memory, in these steps:
// index reduction, memory read, product register, two saturating add steps
// (the paired terms of mu A, mu B and rho add in order), then the write back.
// Configuration: APB port, five 1-bit enable registers at byte offsets 0..16; they
// must be written only while the block is idle, which it does not enforce. pready is tied high.
// Reset (i_rst_n low, synchronous) clears the registers and the sequencer; the
// sum memory is not cleared, so every point needs a clear item before use.
// Disabled sums read back as zero and are left untouched in memory.
module zero_lag_xcorr_accumulator #(
    parameter int GRID_POINTS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  zlxc_pkg::t_in       i_item,
    output logic                busy,
    output logic                o_done,
    output zlxc_pkg::t_out      o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
    localparam int IB = zlxc_pkg::INDEX_BITS;
    localparam int AB = zlxc_pkg::ACC_BITS;
    localparam int PB = zlxc_pkg::PROD_BITS;
    localparam int LB = zlxc_pkg::LPROD_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_IDX  = 6'b000010,
        S_MUL  = 6'b000100,
        S_ADD1 = 6'b001000,
        S_ADD2 = 6'b010000,
        S_WR   = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    zlxc_pkg::t_cfg              r_cfg;
    zlxc_pkg::t_en               r_en, n_en;
    zlxc_pkg::t_in               r_item;
    zlxc_pkg::t_out              r_acc, n_acc, w_sum, r_result, w_rd;
    zlxc_pkg::t_prod             w_prod;
    logic                        r_done;
    logic [AW-1:0]               r_addr, w_addr;
    logic [zlxc_pkg::MEM_BITS-1:0] w_rdata;
    logic                        w_accept, w_is_acc, w_is_clr, w_add1, w_add2, w_we;
    logic [LB-1:0]               w_p_mu_a, w_p_mu_b, w_p_rho;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign w_is_acc = (r_item.operation == zlxc_pkg::OP_ACC);
    assign w_is_clr = (r_item.operation == zlxc_pkg::OP_CLEAR);
    assign w_add1   = (r_state == S_ADD1);
    assign w_add2   = (r_state == S_ADD2);
    assign w_we     = (r_state == S_WR) && (w_is_acc || w_is_clr);

    // point_index modulo GRID_POINTS
    generate
        if (GRID_POINTS >= (1 << IB)) begin : g_idx_direct
            assign w_addr = AW'(r_item.point_index);
        end else begin : g_idx_mod
            localparam int SH = IB + AW;
            localparam int RB = IB + 2;
            localparam longint unsigned RECIP_L =
                ((64'd1 << SH) + GRID_POINTS - 1) / GRID_POINTS;
            localparam logic [RB-1:0] RECIP = RB'(RECIP_L);
            localparam logic [IB-1:0] G_L   = IB'(GRID_POINTS);

            logic [IB+RB-1:0] w_qfull;
            logic [IB-1:0]    r_quot;
            logic [IB-1:0]    w_qg;
            logic [IB-1:0]    w_rem;

            assign w_qfull = i_item.point_index * RECIP;
            assign w_qg    = r_quot * G_L;
            assign w_rem   = r_item.point_index - w_qg;
            assign w_addr  = w_rem[AW-1:0];

            always_ff @(posedge i_clk) begin
                if (w_accept) begin
                    r_quot <= IB'(w_qfull >> SH);
                end
            end
        end
    endgenerate

    zlxc_ram #(
        .WIDTH (zlxc_pkg::MEM_BITS),
        .DEPTH (GRID_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (r_acc),
        .i_re    (r_state == S_IDX),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    zlxc_prod u_prod (
        .i_clk  (i_clk),
        .i_item (r_item),
        .o_prod (w_prod)
    );

    // second add step takes the paired term of each two-term sum
    assign w_p_mu_a = w_add1 ? {{(LB-PB){w_prod.mu_a1[PB-1]}}, w_prod.mu_a1}
                             : {{(LB-PB){w_prod.mu_a2[PB-1]}}, w_prod.mu_a2};
    assign w_p_mu_b = w_add1 ? {{(LB-PB){w_prod.mu_b1[PB-1]}}, w_prod.mu_b1}
                             : {{(LB-PB){w_prod.mu_b2[PB-1]}}, w_prod.mu_b2};
    assign w_p_rho  = w_add1 ? {{(LB-PB){w_prod.rho1[PB-1]}}, w_prod.rho1}
                             : {{(LB-PB){w_prod.rho2[PB-1]}}, w_prod.rho2};

    zlxc_sat_add u_add_lambda (
        .i_acc  (r_acc.sum_lambda),
        .i_prod (w_prod.lambda),
        .i_en   (w_add1 && w_is_acc && r_en.lambda),
        .o_sum  (w_sum.sum_lambda)
    );

    zlxc_sat_add u_add_mu_a (
        .i_acc  (r_acc.sum_mu_a),
        .i_prod (w_p_mu_a),
        .i_en   ((w_add1 || w_add2) && w_is_acc && r_en.mu),
        .o_sum  (w_sum.sum_mu_a)
    );

    zlxc_sat_add u_add_mu_b (
        .i_acc  (r_acc.sum_mu_b),
        .i_prod (w_p_mu_b),
        .i_en   ((w_add1 || w_add2) && w_is_acc && r_en.mu),
        .o_sum  (w_sum.sum_mu_b)
    );

    zlxc_sat_add u_add_mu_c (
        .i_acc  (r_acc.sum_mu_c),
        .i_prod ({{(LB-PB){w_prod.mu_c[PB-1]}}, w_prod.mu_c}),
        .i_en   (w_add1 && w_is_acc && r_en.mu),
        .o_sum  (w_sum.sum_mu_c)
    );

    zlxc_sat_add u_add_rho (
        .i_acc  (r_acc.sum_rho),
        .i_prod (w_p_rho),
        .i_en   ((w_add1 || w_add2) && w_is_acc && r_en.rho),
        .o_sum  (w_sum.sum_rho)
    );

    always_comb begin
        n_en.rho    = r_cfg.invert_density || r_cfg.invert_porosity
                   || r_cfg.invert_saturation;
        n_en.mu     = r_cfg.invert_vs || n_en.rho;
        n_en.lambda = r_cfg.invert_vp || n_en.mu;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_IDX;
                end
            end
            S_IDX:   n_state = S_MUL;
            S_MUL:   n_state = S_ADD1;
            S_ADD1:  n_state = S_ADD2;
            S_ADD2:  n_state = S_WR;
            S_WR:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_rd = zlxc_pkg::t_out'(w_rdata);

    always_comb begin
        n_acc = r_acc;
        case (r_state)
            S_MUL: begin
                n_acc = w_rd;
                if (w_is_clr) begin
                    if (r_en.lambda) begin
                        n_acc.sum_lambda = '0;
                    end
                    if (r_en.mu) begin
                        n_acc.sum_mu_a = '0;
                        n_acc.sum_mu_b = '0;
                        n_acc.sum_mu_c = '0;
                    end
                    if (r_en.rho) begin
                        n_acc.sum_rho = '0;
                    end
                end
            end
            S_ADD1, S_ADD2: begin
                n_acc = w_sum;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cfg   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= w_add2;
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    zlxc_pkg::REG_INVERT_VP:         r_cfg.invert_vp         <= pwdata[0];
                    zlxc_pkg::REG_INVERT_VS:         r_cfg.invert_vs         <= pwdata[0];
                    zlxc_pkg::REG_INVERT_DENSITY:    r_cfg.invert_density    <= pwdata[0];
                    zlxc_pkg::REG_INVERT_POROSITY:   r_cfg.invert_porosity   <= pwdata[0];
                    zlxc_pkg::REG_INVERT_SATURATION: r_cfg.invert_saturation <= pwdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
            r_en   <= n_en;
        end
        if (r_state == S_IDX) begin
            r_addr <= w_addr;
        end
        r_acc <= n_acc;
        if (w_add2) begin
            r_result.sum_lambda <= r_en.lambda ? w_sum.sum_lambda : '0;
            r_result.sum_mu_a   <= r_en.mu     ? w_sum.sum_mu_a   : '0;
            r_result.sum_mu_b   <= r_en.mu     ? w_sum.sum_mu_b   : '0;
            r_result.sum_mu_c   <= r_en.mu     ? w_sum.sum_mu_c   : '0;
            r_result.sum_rho    <= r_en.rho    ? w_sum.sum_rho    : '0;
        end
    end

    always_comb begin
        case (paddr[4:2])
            zlxc_pkg::REG_INVERT_VP:         prdata = {31'd0, r_cfg.invert_vp};
            zlxc_pkg::REG_INVERT_VS:         prdata = {31'd0, r_cfg.invert_vs};
            zlxc_pkg::REG_INVERT_DENSITY:    prdata = {31'd0, r_cfg.invert_density};
            zlxc_pkg::REG_INVERT_POROSITY:   prdata = {31'd0, r_cfg.invert_porosity};
            zlxc_pkg::REG_INVERT_SATURATION: prdata = {31'd0, r_cfg.invert_saturation};
            default:                         prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign o_done   = r_done;
    assign o_result = r_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_done)
        else $error("result strobe not five cycles after accept");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy && !w_accept)
        else $error("result shown while block accepts items");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && w_is_clr && r_en.mu |-> (o_result.sum_mu_a == '0)
            && (o_result.sum_mu_b == '0) && (o_result.sum_mu_c == '0))
        else $error("clear item returned nonzero mu sums");

endmodule

/* sim/zero_lag_xcorr_accumulator_test.sv */
module zero_lag_xcorr_accumulator_test;

    localparam int GRID = 65536;
    localparam logic [1:0] OP_READ_ALIAS = 2'd3;   // undefined code, behaves as a read
    localparam longint ACC_MAX = (longint'(1) <<< (zlxc_pkg::ACC_BITS - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT = 2000;
    localparam int SETTING_ITEMS = 36;
    localparam int NUM_SETTINGS = 12;
    // full-scale accumulates on one point
    localparam int SAT_RUN_ITEMS = 20;
    localparam logic [zlxc_pkg::INDEX_BITS-1:0] SAT_POINT = 16'h8001;
    localparam int POOL_SIZE = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    zlxc_pkg::t_in     i_item = '0;
    logic              busy;
    logic              o_done;
    zlxc_pkg::t_out    o_result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    zero_lag_xcorr_accumulator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    class xcorr_sums_tracker;
        zlxc_pkg::t_cfg   cfg;
        longint           lambda_sum [GRID];
        longint           mu_a_sum [GRID];
        longint           mu_b_sum [GRID];
        longint           mu_c_sum [GRID];
        longint           rho_sum [GRID];
        zlxc_pkg::t_out   pending_sums [$];
        int               fail_count;
        int               result_count;

        function zlxc_pkg::t_en enabled_groups();
            zlxc_pkg::t_en en;
            en.rho    = cfg.invert_density | cfg.invert_porosity | cfg.invert_saturation;
            en.mu     = cfg.invert_vs | en.rho;
            en.lambda = cfg.invert_vp | en.mu;
            return en;
        endfunction

        function longint sat_add(longint acc, longint term);
            longint s;
            s = acc + term;
            if (s > ACC_MAX) return ACC_MAX;
            if (s < ACC_MIN) return ACC_MIN;
            return s;
        endfunction

        function void note_item(zlxc_pkg::t_in it);
            zlxc_pkg::t_en  en;
            int             p;
            longint         fxx, fyy, fxy, fvx, fvy, axx, ayy, axy, avx, avy;
            zlxc_pkg::t_out r;
            en = enabled_groups();
            p = it.point_index % GRID;
            fxx = $signed(it.fwd_sxx);
            fyy = $signed(it.fwd_syy);
            fxy = $signed(it.fwd_sxy);
            fvx = $signed(it.fwd_vx);
            fvy = $signed(it.fwd_vy);
            axx = $signed(it.adj_sxx);
            ayy = $signed(it.adj_syy);
            axy = $signed(it.adj_sxy);
            avx = $signed(it.adj_vx);
            avy = $signed(it.adj_vy);
            if (it.operation == zlxc_pkg::OP_ACC) begin
                if (en.lambda)
                    lambda_sum[p] = sat_add(lambda_sum[p], (fxx + fyy) * (axx + ayy));
                if (en.mu) begin
                    // paired terms clip one after the other
                    mu_a_sum[p] = sat_add(mu_a_sum[p], fxx * axx);
                    mu_a_sum[p] = sat_add(mu_a_sum[p], fyy * ayy);
                    mu_b_sum[p] = sat_add(mu_b_sum[p], fyy * axx);
                    mu_b_sum[p] = sat_add(mu_b_sum[p], fxx * ayy);
                    mu_c_sum[p] = sat_add(mu_c_sum[p], fxy * axy);
                end
                if (en.rho) begin
                    rho_sum[p] = sat_add(rho_sum[p], fvx * avx);
                    rho_sum[p] = sat_add(rho_sum[p], fvy * avy);
                end
            end else if (it.operation == zlxc_pkg::OP_CLEAR) begin
                if (en.lambda) lambda_sum[p] = 0;
                if (en.mu) begin
                    mu_a_sum[p] = 0;
                    mu_b_sum[p] = 0;
                    mu_c_sum[p] = 0;
                end
                if (en.rho) rho_sum[p] = 0;
            end
            r = '0;
            if (en.lambda) r.sum_lambda = lambda_sum[p][zlxc_pkg::ACC_BITS-1:0];
            if (en.mu) begin
                r.sum_mu_a = mu_a_sum[p][zlxc_pkg::ACC_BITS-1:0];
                r.sum_mu_b = mu_b_sum[p][zlxc_pkg::ACC_BITS-1:0];
                r.sum_mu_c = mu_c_sum[p][zlxc_pkg::ACC_BITS-1:0];
            end
            if (en.rho) r.sum_rho = rho_sum[p][zlxc_pkg::ACC_BITS-1:0];
            pending_sums.push_back(r);
        endfunction

        function void compare_field(string name, logic [zlxc_pkg::ACC_BITS-1:0] want,
                                    logic [zlxc_pkg::ACC_BITS-1:0] got);
            if (got !== want) begin
                fail_count++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(zlxc_pkg::t_out got);
            zlxc_pkg::t_out want;
            result_count++;
            if (pending_sums.size() == 0) begin
                fail_count++;
                $display("%0t: result with no item pending, expected none actual %h",
                         $time, got);
                return;
            end
            want = pending_sums.pop_front();
            compare_field("sum_lambda", want.sum_lambda, got.sum_lambda);
            compare_field("sum_mu_a", want.sum_mu_a, got.sum_mu_a);
            compare_field("sum_mu_b", want.sum_mu_b, got.sum_mu_b);
            compare_field("sum_mu_c", want.sum_mu_c, got.sum_mu_c);
            compare_field("sum_rho", want.sum_rho, got.sum_rho);
        endfunction
    endclass

    xcorr_sums_tracker sums;
    // groups of each point cleared since reset: {lambda, mu, rho}
    bit [2:0] cleared_groups [GRID];
    logic [zlxc_pkg::INDEX_BITS-1:0] point_pool [POOL_SIZE];
    int items_sent;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sums.check_result(o_result);
    end

    function automatic logic signed [zlxc_pkg::SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return zlxc_pkg::SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic zlxc_pkg::t_in make_item(logic [1:0] op,
                                                logic [zlxc_pkg::INDEX_BITS-1:0] idx,
                                                logic signed [zlxc_pkg::SAMPLE_BITS-1:0] fwd,
                                                logic signed [zlxc_pkg::SAMPLE_BITS-1:0] adj);
        zlxc_pkg::t_in it;
        it.operation = op;
        it.point_index = idx;
        it.fwd_sxx = fwd;
        it.fwd_syy = fwd;
        it.fwd_sxy = fwd;
        it.fwd_vx  = fwd;
        it.fwd_vy  = fwd;
        it.adj_sxx = adj;
        it.adj_syy = adj;
        it.adj_sxy = adj;
        it.adj_vx  = adj;
        it.adj_vy  = adj;
        return it;
    endfunction

    function automatic zlxc_pkg::t_in random_item(logic [zlxc_pkg::INDEX_BITS-1:0] idx);
        zlxc_pkg::t_in it;
        int            r;
        r = $urandom_range(0, 99);
        it.operation = (r < 60) ? zlxc_pkg::OP_ACC : (r < 75) ? zlxc_pkg::OP_CLEAR :
                       (r < 90) ? zlxc_pkg::OP_READ : OP_READ_ALIAS;
        it.point_index = idx;
        it.fwd_sxx = rand_sample();
        it.fwd_syy = rand_sample();
        it.fwd_sxy = rand_sample();
        it.fwd_vx  = rand_sample();
        it.fwd_vy  = rand_sample();
        it.adj_sxx = rand_sample();
        it.adj_syy = rand_sample();
        it.adj_sxy = rand_sample();
        it.adj_vx  = rand_sample();
        it.adj_vy  = rand_sample();
        return it;
    endfunction

    function automatic logic [zlxc_pkg::INDEX_BITS-1:0] pick_point();
        if ($urandom_range(0, 9) == 0)
            return zlxc_pkg::INDEX_BITS'($urandom());
        return point_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom() & ~32'd1) | {31'd0, value};   // upper bits are don't care
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'd0, value}) begin
            sums.fail_count++;
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, idx, {31'd0, value}, prdata);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_cfg(zlxc_pkg::t_cfg c);
        write_reg(zlxc_pkg::REG_INVERT_VP, c.invert_vp);
        write_reg(zlxc_pkg::REG_INVERT_VS, c.invert_vs);
        write_reg(zlxc_pkg::REG_INVERT_DENSITY, c.invert_density);
        write_reg(zlxc_pkg::REG_INVERT_POROSITY, c.invert_porosity);
        write_reg(zlxc_pkg::REG_INVERT_SATURATION, c.invert_saturation);
        sums.cfg = c;
    endtask

    // Any use of a point whose enabled sums were never cleared becomes a clear.
    task automatic send_item(zlxc_pkg::t_in it, int gap_pct);
        bit [2:0] need;
        need = sums.enabled_groups();
        if (it.operation != zlxc_pkg::OP_CLEAR
                && (cleared_groups[it.point_index] & need) != need)
            it.operation = zlxc_pkg::OP_CLEAR;
        if (it.operation == zlxc_pkg::OP_CLEAR)
            cleared_groups[it.point_index] |= need;
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sums.note_item(it);
        items_sent++;
        if ($urandom_range(0, 99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        int n;
        n = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (sums.pending_sums.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        zlxc_pkg::t_cfg settings [NUM_SETTINGS];
        zlxc_pkg::t_in  it;
        int             gap;

        sums = new();
        sums.cfg = '0;
        items_sent = 0;
        point_pool = '{16'h0000, 16'hffff, 16'h5555, 16'haaaa, 16'h0001,
                       16'h8000, 16'h1234, 16'hedcb};
        point_pool[6] = zlxc_pkg::INDEX_BITS'($urandom());
        point_pool[7] = zlxc_pkg::INDEX_BITS'($urandom());
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing enabled after reset: every sum reads zero, any point may be used
        send_item(make_item(zlxc_pkg::OP_ACC, 16'h1234, 16'sh7fff, 16'sh7fff), 0);
        send_item(make_item(zlxc_pkg::OP_READ, 16'hffff, 16'sh8000, 16'sh0001), 0);
        send_item(make_item(OP_READ_ALIAS, 16'h0000, 16'sh0000, 16'sh0000), 0);
        drain();

        apply_cfg(zlxc_pkg::t_cfg'(5'b11111));
        send_item(make_item(zlxc_pkg::OP_CLEAR, 16'h0000, 16'sh7fff, 16'sh8000), 0);
        send_item(make_item(zlxc_pkg::OP_CLEAR, 16'hffff, 16'sh8000, 16'sh8000), 0);
        send_item(make_item(zlxc_pkg::OP_ACC, 16'h0000, 16'sh7fff, 16'sh7fff), 0);
        send_item(make_item(zlxc_pkg::OP_ACC, 16'h0000, 16'sh8000, 16'sh8000), 0);
        send_item(make_item(zlxc_pkg::OP_ACC, 16'h0000, 16'sh8000, 16'sh7fff), 0);
        send_item(make_item(zlxc_pkg::OP_ACC, 16'hffff, 16'sh7fff, 16'sh8000), 0);
        send_item(make_item(zlxc_pkg::OP_ACC, 16'hffff, 16'sh0000, 16'sh0000), 0);
        it = make_item(zlxc_pkg::OP_ACC, 16'hffff, 16'sh8000, 16'sh7fff);
        it.fwd_syy = 16'sh7fff;
        it.adj_syy = 16'sh8000;
        it.fwd_vy = 16'sh0001;
        it.adj_vx = 16'shffff;
        send_item(it, 0);
        send_item(make_item(zlxc_pkg::OP_ACC, 16'h0000, 16'shffff, 16'sh0001), 0);
        send_item(make_item(zlxc_pkg::OP_READ, 16'h0000, 16'shffff, 16'shffff), 0);
        send_item(make_item(OP_READ_ALIAS, 16'hffff, 16'sh7fff, 16'sh7fff), 0);
        send_item(make_item(zlxc_pkg::OP_CLEAR, 16'h0000, 16'sh1234, 16'sh4321), 0);
        send_item(make_item(zlxc_pkg::OP_READ, 16'h0000, 16'sh0000, 16'sh0000), 0);

        settings = '{zlxc_pkg::t_cfg'(5'b10000), zlxc_pkg::t_cfg'(5'b01000),
                     zlxc_pkg::t_cfg'(5'b00100), zlxc_pkg::t_cfg'(5'b00010),
                     zlxc_pkg::t_cfg'(5'b00001), zlxc_pkg::t_cfg'(5'b11000),
                     zlxc_pkg::t_cfg'(5'b10101), zlxc_pkg::t_cfg'(5'b00000),
                     zlxc_pkg::t_cfg'(5'b11111), zlxc_pkg::t_cfg'(5'b01001),
                     zlxc_pkg::t_cfg'(5'b00000), zlxc_pkg::t_cfg'(5'b00000)};
        settings[10] = zlxc_pkg::t_cfg'(5'($urandom_range(0, 31)));
        settings[11] = zlxc_pkg::t_cfg'(5'($urandom_range(0, 31)));
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain();
            apply_cfg(settings[s]);
            gap = (s < 4) ? 20 : (s < 8) ? 87 : 0;
            repeat (SETTING_ITEMS) send_item(random_item(pick_point()), gap);
        end

        // full-scale products on one point, then random items on top
        drain();
        apply_cfg(zlxc_pkg::t_cfg'(5'b11111));
        send_item(make_item(zlxc_pkg::OP_CLEAR, SAT_POINT, 16'sh0000, 16'sh0000), 0);
        it = make_item(zlxc_pkg::OP_ACC, SAT_POINT, 16'sh8000, 16'sh8000);
        it.adj_sxy = 16'sh7fff;
        it.fwd_vx = 16'sh7fff;
        it.fwd_vy = 16'sh7fff;
        repeat (SAT_RUN_ITEMS) send_item(it, 0);
        repeat (40) begin
            it = random_item(SAT_POINT);
            if (it.operation == zlxc_pkg::OP_CLEAR)
                it.operation = zlxc_pkg::OP_ACC;
            send_item(it, 10);
        end
        drain();

        if (sums.pending_sums.size() != 0) begin
            sums.fail_count += sums.pending_sums.size();
            $display("%0t: %0d results missing, expected %0d actual 0", $time,
                     sums.pending_sums.size(), sums.pending_sums.size());
        end
        $display("Ran %0d items (%0d results) over %0d enable settings plus reset values,",
                 items_sent, sums.result_count, NUM_SETTINGS + 1);
        $display("including a run of %0d full-scale accumulates on one point.",
                 SAT_RUN_ITEMS);
        if (sums.fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog: stop with a failure if the run hangs
    initial begin
        #100000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
